FILE: rtl/srb_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the
// shape rasterizer bitmap unit. No dependencies.
package srb_pkg;

   localparam int CANVAS_WIDTH  = 40;
   localparam int CANVAS_HEIGHT = 20;

   localparam int OP_W    = 2;
   localparam int KIND_W  = 2;
   localparam int CX_W    = 6;
   localparam int CY_W    = 5;
   localparam int EXT_A_W = 6;
   localparam int EXT_B_W = 5;
   localparam int ROW_I_W = 5;
   localparam int ROW_OUT_W = 40;

   localparam int ROW_AW = $clog2(CANVAS_HEIGHT);
   localparam int COORD_W = 10;
   localparam int ROOT_W = EXT_A_W + 1;
   localparam int LIM_W  = 2 * ROOT_W;
   localparam int BIT_W  = $clog2(ROOT_W);

   localparam logic signed [COORD_W-1:0] C_ZERO = COORD_W'(0);
   localparam logic signed [COORD_W-1:0] C_ONE  = COORD_W'(1);
   localparam logic signed [COORD_W-1:0] Y_LAST = COORD_W'(CANVAS_HEIGHT - 1);
   localparam logic signed [COORD_W-1:0] Y_LIMIT = COORD_W'(CANVAS_HEIGHT);

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_RECT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ELLIPSE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LINE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TRI     = 2'd3;

   typedef struct packed {
      logic load;
      logic clear;
      logic setup;
      logic calc_rem;
      logic root_step;
      logic write_row;
      logic read_capture;
   } srb_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            is_ellipse;
      logic            walk_empty;
      logic            last_row;
      logic            root_last;
      logic            rsp_free;
   } srb_status_type;

endpackage

FILE: rtl/srb_req_if.sv
// Command channel: valid/ready with one shape or canvas command per beat.
// Depends on srb_pkg.
interface srb_req_if;
   logic                         valid;
   logic                         ready;
   logic [srb_pkg::OP_W-1:0]     operation;
   logic [srb_pkg::KIND_W-1:0]   shape_kind;
   logic [srb_pkg::CX_W-1:0]     center_x;
   logic [srb_pkg::CY_W-1:0]     center_y;
   logic [srb_pkg::EXT_A_W-1:0]  extent_a;
   logic [srb_pkg::EXT_B_W-1:0]  extent_b;
   logic [srb_pkg::ROW_I_W-1:0]  row_index;

   modport source (output valid, operation, shape_kind, center_x, center_y,
                   extent_a, extent_b, row_index, input ready);
   modport sink (input valid, operation, shape_kind, center_x, center_y,
                 extent_a, extent_b, row_index, output ready);
endinterface

FILE: rtl/srb_rsp_if.sv
// Response channel: valid/ready with one canvas row per beat.
// Depends on srb_pkg.
interface srb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [srb_pkg::ROW_OUT_W-1:0]  row_bits;

   modport source (output valid, row_bits, input ready);
   modport sink (input valid, row_bits, output ready);
endinterface

FILE: rtl/srb_ctrl.sv
// Sequencer for the rasterizer: decodes a command beat and steps the
// datapath row by row. Depends on srb_pkg.
module srb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  srb_pkg::srb_status_type status,
   output srb_pkg::srb_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_REM,
      ST_ROOT,
      ST_WRITE,
      ST_READ
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op)
               srb_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
               srb_pkg::OP_DRAW: begin
                  cmd.setup = 1'b1;
                  state_in  = ST_CHECK;
               end
               srb_pkg::OP_READ: begin
                  state_in = ST_READ;
               end
               srb_pkg::OP_NONE: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_CHECK: begin
            priority if (status.walk_empty) begin
               state_in = ST_IDLE;
            end else if (status.is_ellipse) begin
               state_in = ST_REM;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_REM: begin
            cmd.calc_rem = 1'b1;
            state_in     = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_row = 1'b1;
            priority if (status.last_row) begin
               state_in = ST_IDLE;
            end else if (status.is_ellipse) begin
               state_in = ST_REM;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_READ: begin
            if (status.rsp_free) begin
               cmd.read_capture = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/srb_datapath.sv
// Canvas rows, span generation per shape row, ellipse root unit and the
// response register. Depends on srb_pkg.
module srb_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [srb_pkg::OP_W-1:0]        req_operation,
   input  logic [srb_pkg::KIND_W-1:0]      req_shape_kind,
   input  logic [srb_pkg::CX_W-1:0]        req_center_x,
   input  logic [srb_pkg::CY_W-1:0]        req_center_y,
   input  logic [srb_pkg::EXT_A_W-1:0]     req_extent_a,
   input  logic [srb_pkg::EXT_B_W-1:0]     req_extent_b,
   input  logic [srb_pkg::ROW_I_W-1:0]     req_row_index,
   input  srb_pkg::srb_cmd_type            cmd,
   output srb_pkg::srb_status_type         status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [srb_pkg::ROW_OUT_W-1:0]   rsp_row_bits
);

   localparam int W  = srb_pkg::CANVAS_WIDTH;
   localparam int H  = srb_pkg::CANVAS_HEIGHT;
   localparam int CW = srb_pkg::COORD_W;

   // captured command
   logic [srb_pkg::OP_W-1:0]    op_ff;
   logic [srb_pkg::KIND_W-1:0]  kind_ff;
   logic [srb_pkg::CX_W-1:0]    cx_ff;
   logic [srb_pkg::CY_W-1:0]    cy_ff;
   logic [srb_pkg::EXT_A_W-1:0] a_ff;
   logic [srb_pkg::EXT_B_W-1:0] b_ff;
   logic [srb_pkg::ROW_I_W-1:0] row_ff;

   // row walk
   logic signed [CW-1:0]        y_ff, y_in;
   logic signed [CW-1:0]        y_end_ff, y_end_in;
   logic                        none_ff, none_in;
   logic [srb_pkg::LIM_W-1:0]   lim_ff;
   logic [srb_pkg::LIM_W-1:0]   rem_ff;
   logic [srb_pkg::ROOT_W-1:0]  w_ff;
   logic [srb_pkg::BIT_W-1:0]   bit_ff;
   logic [srb_pkg::EXT_A_W-1:0] q_ff;
   logic [srb_pkg::EXT_A_W-1:0] rr_ff;

   logic [W-1:0]                canvas_ff [H];
   logic                        rsp_valid_ff;
   logic [srb_pkg::ROW_OUT_W-1:0] rsp_bits_ff;

   logic signed [CW-1:0] cx_s, cy_s, a_s, b_s, a_half, b_half;
   logic signed [CW-1:0] ys, ye;
   logic [srb_pkg::EXT_A_W-1:0] h_val;
   logic [srb_pkg::ROOT_W-1:0]  bound;
   logic signed [CW-1:0] dy, dy_abs;
   logic [srb_pkg::EXT_A_W-1:0] dy_mag;
   logic [2*srb_pkg::EXT_A_W-1:0] dy_sq;
   logic [srb_pkg::ROOT_W-1:0]  cand;
   logic [srb_pkg::LIM_W-1:0]   cand_sq;
   logic signed [CW-1:0] xa, xb;
   logic [W-1:0]         mask;
   logic                 y_in_canvas;
   logic [srb_pkg::ROW_AW-1:0] y_idx, rd_idx;
   logic [srb_pkg::ROW_I_W+srb_pkg::ROW_AW-1:0] row_ext;
   logic                 row_ok;
   logic [W-1:0]         cur_row;
   logic [srb_pkg::ROW_OUT_W+W-1:0] row_wide;

   assign cx_s   = signed'(CW'(cx_ff));
   assign cy_s   = signed'(CW'(cy_ff));
   assign a_s    = signed'(CW'(a_ff));
   assign b_s    = signed'(CW'(b_ff));
   assign a_half = signed'(CW'(a_ff >> 1));
   assign b_half = signed'(CW'(b_ff >> 1));
   assign h_val  = a_ff >> 1;
   assign bound  = {a_ff, 1'b1};

   // row range of the shape
   always_comb begin
      unique case (kind_ff)
         srb_pkg::KIND_RECT: begin
            ys      = cy_s - b_half;
            ye      = ys + b_s - srb_pkg::C_ONE;
            none_in = (a_ff == '0);
         end
         srb_pkg::KIND_ELLIPSE: begin
            ys      = cy_s - a_s;
            ye      = cy_s + a_s;
            none_in = 1'b0;
         end
         srb_pkg::KIND_LINE: begin
            ys      = cy_s - a_half;
            ye      = cy_s + a_half;
            none_in = 1'b0;
         end
         srb_pkg::KIND_TRI: begin
            ys      = cy_s - a_half;
            ye      = cy_s + a_half;
            none_in = (a_ff == '0);
         end
      endcase
      // triangle walks its rows above the canvas to keep the running quotient
      if ((kind_ff != srb_pkg::KIND_TRI) && (ys < srb_pkg::C_ZERO)) begin
         y_in = srb_pkg::C_ZERO;
      end else begin
         y_in = ys;
      end
      y_end_in = (ye > srb_pkg::Y_LAST) ? srb_pkg::Y_LAST : ye;
   end

   // ellipse: rem = (2r+1)^2 - 4 dy^2, then w = floor(sqrt(rem)) one bit a step
   assign dy      = y_ff - cy_s;
   assign dy_abs  = (dy < srb_pkg::C_ZERO) ? -dy : dy;
   assign dy_mag  = dy_abs[srb_pkg::EXT_A_W-1:0];
   assign dy_sq   = (2*srb_pkg::EXT_A_W)'(dy_mag) * (2*srb_pkg::EXT_A_W)'(dy_mag);
   assign cand    = w_ff | (srb_pkg::ROOT_W'(1) << bit_ff);
   assign cand_sq = srb_pkg::LIM_W'(cand) * srb_pkg::LIM_W'(cand);

   // span of the current row
   always_comb begin
      unique case (kind_ff)
         srb_pkg::KIND_RECT: begin
            xa = cx_s - a_half;
            xb = xa + a_s - srb_pkg::C_ONE;
         end
         srb_pkg::KIND_ELLIPSE: begin
            xa = cx_s - signed'(CW'(w_ff));
            xb = cx_s + signed'(CW'(w_ff));
         end
         srb_pkg::KIND_LINE: begin
            xa = cx_s + dy;
            xb = cx_s + dy;
         end
         srb_pkg::KIND_TRI: begin
            xa = cx_s - signed'(CW'(q_ff));
            xb = cx_s + signed'(CW'(q_ff));
         end
      endcase
      for (int c = 0; c < W; c++) begin
         mask[c] = (signed'(CW'(c)) >= xa) && (signed'(CW'(c)) <= xb);
      end
   end

   assign y_in_canvas = (y_ff >= srb_pkg::C_ZERO) && (y_ff < srb_pkg::Y_LIMIT);
   assign y_idx       = y_ff[srb_pkg::ROW_AW-1:0];
   assign row_ext     = {srb_pkg::ROW_AW'(0), row_ff};
   assign row_ok      = (row_ext < (srb_pkg::ROW_I_W+srb_pkg::ROW_AW)'(H));
   assign rd_idx      = cmd.read_capture ? row_ext[srb_pkg::ROW_AW-1:0] : y_idx;
   assign cur_row     = canvas_ff[rd_idx];
   assign row_wide    = {srb_pkg::ROW_OUT_W'(0), cur_row};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         kind_ff <= req_shape_kind;
         cx_ff   <= req_center_x;
         cy_ff   <= req_center_y;
         a_ff    <= req_extent_a;
         b_ff    <= req_extent_b;
         row_ff  <= req_row_index;
      end
      if (cmd.setup) begin
         y_ff     <= y_in;
         y_end_ff <= y_end_in;
         none_ff  <= none_in;
         lim_ff   <= srb_pkg::LIM_W'(bound) * srb_pkg::LIM_W'(bound);
         q_ff     <= '0;
         rr_ff    <= h_val;
      end
      if (cmd.calc_rem) begin
         rem_ff <= lim_ff - {dy_sq, 2'b00};
         w_ff   <= '0;
         bit_ff <= srb_pkg::BIT_W'(srb_pkg::ROOT_W - 1);
      end
      if (cmd.root_step) begin
         if (cand_sq <= rem_ff) begin
            w_ff <= cand;
         end
         bit_ff <= bit_ff - srb_pkg::BIT_W'(1);
      end
      if (cmd.write_row) begin
         y_ff <= y_ff + srb_pkg::C_ONE;
         if (rr_ff >= h_val) begin
            rr_ff <= rr_ff - h_val;
            q_ff  <= q_ff + srb_pkg::EXT_A_W'(1);
         end else begin
            rr_ff <= rr_ff + h_val;
         end
      end
      if (cmd.read_capture) begin
         rsp_bits_ff <= row_ok ? row_wide[srb_pkg::ROW_OUT_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < H; r++) begin
            canvas_ff[r] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            for (int r = 0; r < H; r++) begin
               canvas_ff[r] <= '0;
            end
         end else if (cmd.write_row && y_in_canvas) begin
            canvas_ff[y_idx] <= cur_row | mask;
         end
         if (cmd.read_capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.op         = op_ff;
   assign status.is_ellipse = (kind_ff == srb_pkg::KIND_ELLIPSE);
   assign status.walk_empty = none_ff || (y_ff > y_end_ff);
   assign status.last_row   = (y_ff == y_end_ff);
   assign status.root_last  = (bit_ff == '0);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row_bits = rsp_bits_ff;

endmodule

FILE: rtl/shape_rasterizer_bitmap_unit.sv
// Shape rasterizer bitmap unit, top level: sequencer plus canvas datapath.
// Depends on srb_pkg, srb_req_if, srb_rsp_if, srb_ctrl, srb_datapath.
// Clear: decode, then clear. Read: decode, capture; response offered with ready.
// Draw: decode, setup, check, then per walked row a write (canvas rows; triangle
// also above; ellipse adds rem/root steps). Only a read waits on a stalled response.
// Reset (synchronous) clears the canvas and empties the response register.
module shape_rasterizer_bitmap_unit (
   input logic       clock,
   input logic       reset,
   srb_req_if.sink   req_bus,
   srb_rsp_if.source rsp_bus
);

   srb_pkg::srb_cmd_type    cmd;
   srb_pkg::srb_status_type status;

   srb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   srb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_bus.operation),
      .req_shape_kind (req_bus.shape_kind),
      .req_center_x   (req_bus.center_x),
      .req_center_y   (req_bus.center_y),
      .req_extent_a   (req_bus.extent_a),
      .req_extent_b   (req_bus.extent_b),
      .req_row_index  (req_bus.row_index),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_row_bits   (rsp_bus.row_bits)
   );

endmodule

FILE: rtl/srb_checker.sv
// Port-level assertions for the rasterizer top level, bound in below.
// Depends on srb_pkg and shape_rasterizer_bitmap_unit.
module srb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [srb_pkg::OP_W-1:0]      req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [srb_pkg::ROW_OUT_W-1:0] rsp_row_bits
);

   a_reset_empties_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_bits))
      else $error("stalled response beat changed");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted beat");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == srb_pkg::OP_READ) && !rsp_valid
      |-> ##3 rsp_valid)
      else $error("read beat not answered in time");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared while idle");

endmodule

bind shape_rasterizer_bitmap_unit srb_checker u_srb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_operation (req_bus.operation),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_row_bits  (rsp_bus.row_bits)
);
